/* sv/reb_pkg.sv */
// reb_pkg: shared types and constants for the rotary encoder / button event block.
// Beat structs for both channels, the encoder direction enum, the event groups
// passed between submodules and the threshold reset value. No dependencies.
`default_nettype none

package reb_pkg;

	// One input sample
	typedef struct packed {
		logic a_level;
		logic b_level;
		logic button_level;  // active low
	} in_beat_t;

	// One result
	typedef struct packed {
		logic cw_step;
		logic ccw_step;
		logic short_press;
		logic long_hold;
	} out_beat_t;

	// Pending encoder direction
	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	// Encoder events of one sample
	typedef struct packed {
		logic cw;
		logic ccw;
	} step_ev_t;

	// Button events of one sample
	typedef struct packed {
		logic short_press;
		logic long_hold;
	} press_ev_t;

	localparam int unsigned CFG_WIDTH = 16;
	localparam logic [CFG_WIDTH-1:0] HOLD_LIMIT_RESET = 16'd1500;

endpackage

`default_nettype wire

/* sv/rotary_encoder_button_events.sv */
// rotary_encoder_button_events: top level, handshake stages and threshold register.
// Depends on reb_pkg, reb_quad and reb_button.
//
// Takes one sample beat (encoder A, B, active-low button) per cycle unless the
// output is stalled, and returns exactly one result beat per sample, flagging
// clockwise and counter-clockwise detent steps, short presses and long presses.
// A sample lands in an input register, is evaluated against the encoder and
// button state in one pass of short logic, and the result is held in an output
// register, which drives out_valid. Throughput is one beat per cycle while the
// output is not stalled. Ready drops only while both stages hold a beat and the
// output is stalled. The user must write the hold threshold via cfg_we /
// cfg_wdata only while the block is idle; nothing in the block enforces this.
// A long press fires when the hold count exceeds the threshold.
// TIME_WIDTH sets the hold timer width; the timer saturates, so a threshold
// at or above its maximum disables long presses.
`default_nettype none

module rotary_encoder_button_events #(
	parameter int unsigned TIME_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire reb_pkg::in_beat_t             in_data,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      reb_pkg::out_beat_t            out_data,
	input  wire logic                          cfg_we,
	input  wire logic [reb_pkg::CFG_WIDTH-1:0] cfg_wdata
);

	// threshold register
	logic [reb_pkg::CFG_WIDTH-1:0] hold_limit_q;

	// input stage
	logic              valid_s1;
	reb_pkg::in_beat_t data_s1;

	// result stage
	logic               valid_s2;
	reb_pkg::out_beat_t data_s2;

	logic               adv;   // s1 beat moves into the result register
	logic               fire;  // evaluate s1 and update state
	reb_pkg::step_ev_t  step_ev;
	reb_pkg::press_ev_t press_ev;

	assign adv      = !valid_s2 || out_ready;
	assign fire     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_limit_q <= reb_pkg::HOLD_LIMIT_RESET;
		end else if (cfg_we) begin
			hold_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv)      valid_s2 <= valid_s1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) data_s1 <= in_data;
		if (fire) begin
			data_s2.cw_step     <= step_ev.cw;
			data_s2.ccw_step    <= step_ev.ccw;
			data_s2.short_press <= press_ev.short_press;
			data_s2.long_hold   <= press_ev.long_hold;
		end
	end

	reb_quad u_quad (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.a      (data_s1.a_level),
		.b      (data_s1.b_level),
		.ev     (step_ev)
	);

	reb_button #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_button (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (fire),
		.btn        (data_s1.button_level),
		.hold_limit (hold_limit_q),
		.ev         (press_ev)
	);

`ifndef NO_ASSERTIONS
	// backpressure only when both stages are full and output stalls
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("in_ready low without full stall");

	// an evaluated sample always shows up in the result register
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("evaluated sample lost");

	// a single sample cannot complete steps in both directions
	a_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(data_s2.cw_step && data_s2.ccw_step))
		else $error("cw and ccw step in same beat");

	// a release and a long press never coincide
	a_press_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(data_s2.short_press && data_s2.long_hold))
		else $error("short and long press in same beat");
`endif

endmodule

`default_nettype wire

/* sv/reb_quad.sv */
// reb_quad: quadrature step decoder for encoder lines A and B.
// Holds last A level and the pending direction; uses reb_pkg types.
`default_nettype none

module reb_quad (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic            a,
	input  wire logic            b,
	output reb_pkg::step_ev_t    ev
);

	logic          last_a_q;
	reb_pkg::dir_t dir_q;
	reb_pkg::dir_t dir_d;
	logic          a_chg;

	assign a_chg = (a != last_a_q);

	// next state
	always_comb begin
		dir_d = dir_q;
		if (a_chg) begin
			if (!a) begin
				dir_d = b ? reb_pkg::DIR_CW : reb_pkg::DIR_CCW;
			end else begin
				unique case (dir_q)
					reb_pkg::DIR_CW:  if (!b) dir_d = reb_pkg::DIR_NONE;
					reb_pkg::DIR_CCW: if (b)  dir_d = reb_pkg::DIR_NONE;
					reb_pkg::DIR_NONE: ;
					default: ;
				endcase
			end
		end
	end

	// outputs: step completes on rising A with B opposite to latch level
	always_comb begin
		ev = '0;
		if (a_chg && a) begin
			unique case (dir_q)
				reb_pkg::DIR_CW:   ev.cw  = !b;
				reb_pkg::DIR_CCW:  ev.ccw = b;
				reb_pkg::DIR_NONE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= 1'b1;
			dir_q    <= reb_pkg::DIR_NONE;
		end else if (step) begin
			last_a_q <= a;
			dir_q    <= dir_d;
		end
	end

endmodule

`default_nettype wire

/* sv/reb_button.sv */
// reb_button: button edge detect, saturating hold timer, short/long press events.
// Uses reb_pkg types and the threshold width from reb_pkg.
`default_nettype none

module reb_button #(
	parameter int unsigned TIME_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic                          btn,
	input  wire logic [reb_pkg::CFG_WIDTH-1:0] hold_limit,
	output reb_pkg::press_ev_t                 ev
);

	localparam int unsigned CMP_W =
		(TIME_WIDTH > reb_pkg::CFG_WIDTH) ? TIME_WIDTH : reb_pkg::CFG_WIDTH;

	logic                  last_btn_q;
	logic                  held_q;
	logic [TIME_WIDTH-1:0] hold_q;

	logic                  chg;
	logic [TIME_WIDTH-1:0] hold_d;
	logic                  held_mid;
	logic                  held_d;

	assign chg = (btn != last_btn_q);

	always_comb begin
		if (chg) begin
			hold_d = '0;
		end else if (hold_q != '1) begin
			hold_d = hold_q + TIME_WIDTH'(1);
		end else begin
			hold_d = hold_q;
		end
	end

	// press arms, any release disarms
	assign held_mid = chg ? !btn : held_q;

	assign ev.short_press = chg && btn && held_q;
	assign ev.long_hold   = held_mid && (CMP_W'(hold_d) > CMP_W'(hold_limit));
	assign held_d         = held_mid && !ev.long_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_btn_q <= 1'b1;
			held_q     <= 1'b0;
			hold_q     <= '0;
		end else if (step) begin
			last_btn_q <= btn;
			held_q     <= held_d;
			hold_q     <= hold_d;
		end
	end

endmodule

`default_nettype wire
